// File: design/mlds_pkg.sv
// Shared types, constants and codes for the modulated light differential sampler.
package mlds_pkg;

    localparam int SAMPLE_BITS     = 12;
    localparam int WINDOW_LOG2     = 3;
    localparam int DECIMATION_LOG2 = 2;
    localparam int RING_DEPTH      = 256;

    localparam int WINDOW_LEN = 1 << WINDOW_LOG2;
    localparam int DECIM_LEN  = 1 << DECIMATION_LOG2;

    localparam int BURST_W = 7;
    localparam int WSTART_W = 6;
    localparam int CFG_W   = (BURST_W > WSTART_W) ? BURST_W : WSTART_W;
    localparam int CFG_IDX_W = 1;
    localparam int SUM_W   = SAMPLE_BITS + WINDOW_LOG2;
    localparam int ACC_W   = 16;
    localparam int DATA_W  = 14;
    localparam int SLOT_W  = 8;
    localparam int PTR_W   = $clog2(RING_DEPTH);
    localparam int COUNT_W = (DECIMATION_LOG2 > 0) ? DECIMATION_LOG2 : 1;

    localparam logic [BURST_W-1:0]  BURST_LENGTH_RESET = 7'd26;
    localparam logic [WSTART_W-1:0] WINDOW_START_RESET = 6'd18;

    localparam logic [CFG_IDX_W-1:0] CFG_BURST_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 1'b1;

    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam logic [1:0] SLOT_LIT  = 2'b01;
    localparam logic [1:0] SLOT_DARK = 2'b10;
    localparam logic [1:0] SLOT_BOTH = 2'b11;

    typedef struct packed {
        logic                   kind;
        logic [SAMPLE_BITS-1:0] sample;
    } t_in_beat;

    typedef struct packed {
        logic              emitter_pin;
        logic              data_valid;
        logic [DATA_W-1:0] data_value;
        logic [SLOT_W-1:0] slot_index;
    } t_out_beat;

    typedef struct packed {
        logic [BURST_W-1:0]  burst_length;
        logic [WSTART_W-1:0] window_start;
    } t_cfg;

    typedef struct packed {
        logic                   lit_phase;
        logic                   pin_level;
        logic [BURST_W-1:0]     burst_position;
        logic [SUM_W-1:0]       window_sum;
        logic [SAMPLE_BITS-1:0] lit_average;
        logic [SAMPLE_BITS-1:0] dark_average;
        logic [1:0]             slots_filled;
        logic [ACC_W-1:0]       difference_accumulator;
        logic [COUNT_W-1:0]     difference_count;
        logic [PTR_W-1:0]       ring_pointer;
    } t_state;

    localparam t_state STATE_RESET = '{
        lit_phase:              1'b0,
        pin_level:              1'b0,
        burst_position:         BURST_LENGTH_RESET,
        window_sum:             '0,
        lit_average:            '0,
        dark_average:           '0,
        slots_filled:           2'b00,
        difference_accumulator: '0,
        difference_count:       '0,
        ring_pointer:           '0
    };

endpackage

// File: design/mlds_in_if.sv
// Valid/ready channel that carries input beats into the sampler.
interface mlds_in_if;
    logic                valid;
    logic                ready;
    mlds_pkg::t_in_beat  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/mlds_out_if.sv
// Valid/ready channel that carries result beats out of the sampler.
interface mlds_out_if;
    logic                valid;
    logic                ready;
    mlds_pkg::t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/modulated_light_differential_sampler_top.sv
// Top level of the modulated light differential sampler with ambient cancellation.
// The input channel i_in carries beats of kind and sample. A tick beat (kind 0)
// toggles the emitter phase and opens a new burst; a sample beat (kind 1) is
// counted into the open burst and may close it, store a lit or dark average and
// fold lit minus dark into the difference accumulator.
// Every input beat yields exactly one result beat on o_out: the emitter pin level
// and, every fourth difference, a decimated value with its ring slot index.
// The configuration port writes burst_length (index 0) or window_start (index 1)
// at any edge with i_cfg_we high; write only while the block is idle.
// An accepted input beat has its result beat registered for the next cycle, and one
// beat is taken per cycle unless the output stalls: all the work sits between the
// state registers and the result register. The result register is refilled in the
// same cycle in which the receiver takes it, so i_in.ready is low only while a result
// waits and the receiver holds o_out.ready low.
// A synchronous reset clears all state, restores the register defaults, closes
// the burst and empties the result register.
module modulated_light_differential_sampler_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mlds_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mlds_pkg::CFG_W-1:0]     i_cfg_data,
    mlds_in_if.sink                        i_in,
    mlds_out_if.source                     o_out
);

    mlds_pkg::t_cfg      r_cfg;
    mlds_pkg::t_state    r_state;
    mlds_pkg::t_state    n_state;
    mlds_pkg::t_out_beat r_out;
    mlds_pkg::t_out_beat n_out;
    logic                r_out_valid;
    logic                accept;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign accept      = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    mlds_datapath u_datapath (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_beat   (i_in.data),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.burst_length <= mlds_pkg::BURST_LENGTH_RESET;
            r_cfg.window_start <= mlds_pkg::WINDOW_START_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mlds_pkg::CFG_BURST_LENGTH: begin
                    r_cfg.burst_length <= i_cfg_data[mlds_pkg::BURST_W-1:0];
                end
                mlds_pkg::CFG_WINDOW_START: begin
                    r_cfg.window_start <= i_cfg_data[mlds_pkg::WSTART_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mlds_pkg::STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

// File: design/mlds_datapath.sv
// Next-state and result logic for one input beat of the sampler.
module mlds_datapath (
    input  mlds_pkg::t_state    i_state,
    input  mlds_pkg::t_cfg      i_cfg,
    input  mlds_pkg::t_in_beat  i_beat,
    output mlds_pkg::t_state    o_state,
    output mlds_pkg::t_out_beat o_result
);

    logic [mlds_pkg::BURST_W-1:0]     window_end;
    logic                             in_window;
    logic [mlds_pkg::SUM_W-1:0]       sum_next;
    logic [mlds_pkg::BURST_W-1:0]     pos_next;
    logic [mlds_pkg::SAMPLE_BITS-1:0] average;
    logic [mlds_pkg::SAMPLE_BITS-1:0] lit_next;
    logic [mlds_pkg::SAMPLE_BITS-1:0] dark_next;
    logic [1:0]                       filled_next;
    logic [mlds_pkg::ACC_W-1:0]       acc_next;

    always_comb begin
        window_end  = mlds_pkg::BURST_W'(i_cfg.window_start) +
                      mlds_pkg::BURST_W'(mlds_pkg::WINDOW_LEN);
        in_window   = (i_state.burst_position >= mlds_pkg::BURST_W'(i_cfg.window_start)) &&
                      (i_state.burst_position < window_end);
        sum_next    = in_window ? i_state.window_sum + mlds_pkg::SUM_W'(i_beat.sample)
                                : i_state.window_sum;
        pos_next    = i_state.burst_position + mlds_pkg::BURST_W'(1);
        average     = sum_next[mlds_pkg::SUM_W-1:mlds_pkg::WINDOW_LOG2];
        lit_next    = i_state.lit_phase ? average : i_state.lit_average;
        dark_next   = i_state.lit_phase ? i_state.dark_average : average;
        filled_next = i_state.slots_filled |
                      (i_state.lit_phase ? mlds_pkg::SLOT_LIT : mlds_pkg::SLOT_DARK);
        acc_next    = i_state.difference_accumulator + mlds_pkg::ACC_W'(lit_next) -
                      mlds_pkg::ACC_W'(dark_next);

        o_state  = i_state;
        o_result = '0;

        if (i_beat.kind == mlds_pkg::KIND_TICK) begin
            o_state.lit_phase      = ~i_state.lit_phase;
            o_state.pin_level      = i_state.lit_phase;
            o_state.burst_position = '0;
            o_state.window_sum     = '0;
        end else if (i_state.burst_position < i_cfg.burst_length) begin
            o_state.window_sum     = sum_next;
            o_state.burst_position = pos_next;
            if (pos_next == i_cfg.burst_length) begin
                o_state.lit_average  = lit_next;
                o_state.dark_average = dark_next;
                o_state.slots_filled = filled_next;
                if (filled_next == mlds_pkg::SLOT_BOTH) begin
                    o_state.slots_filled = '0;
                    if (i_state.difference_count ==
                        mlds_pkg::COUNT_W'(mlds_pkg::DECIM_LEN - 1)) begin
                        o_result.data_valid = 1'b1;
                        o_result.data_value = mlds_pkg::DATA_W'(
                            acc_next >> mlds_pkg::DECIMATION_LOG2);
                        o_result.slot_index = mlds_pkg::SLOT_W'(i_state.ring_pointer);
                        o_state.difference_accumulator = '0;
                        o_state.difference_count       = '0;
                        o_state.ring_pointer           = i_state.ring_pointer +
                                                         mlds_pkg::PTR_W'(1);
                    end else begin
                        o_state.difference_accumulator = acc_next;
                        o_state.difference_count       = i_state.difference_count +
                                                         mlds_pkg::COUNT_W'(1);
                    end
                end
            end
        end

        o_result.emitter_pin = o_state.pin_level;
    end

endmodule

// File: design/mlds_checker.sv
// Port-level checker for the sampler top level, with its bind statement.
module mlds_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_in_kind,
    input logic                          i_out_valid,
    input logic                          i_out_data_valid,
    input logic [mlds_pkg::DATA_W-1:0]   i_out_data_value,
    input logic [mlds_pkg::SLOT_W-1:0]   i_out_slot_index
);

    a_reset_empties_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result beat present right after reset.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("Input stalled while no result is waiting.");

    a_tick_never_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_kind == mlds_pkg::KIND_TICK)
            |=> (i_out_valid && !i_out_data_valid))
        else $error("Tick beat did not yield a plain result beat.");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_data_valid)
            |-> (i_out_data_value == '0 && i_out_slot_index == '0))
        else $error("Value or slot nonzero on a beat without data.");

endmodule

bind modulated_light_differential_sampler_top mlds_checker u_mlds_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_kind        (i_in.data.kind),
    .i_out_valid      (o_out.valid),
    .i_out_data_valid (o_out.data.data_valid),
    .i_out_data_value (o_out.data.data_value),
    .i_out_slot_index (o_out.data.slot_index)
);

// File: bench/mlds_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the differential sampler that predicts each result beat and compares it.
module mlds_result_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mlds_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mlds_pkg::CFG_W-1:0]     i_cfg_data,
    mlds_in_if                             i_sample_ch,
    mlds_out_if                            i_result_ch,
    output int                             o_mismatch_count,
    output int                             o_pending
);
    import mlds_pkg::*;

    logic [BURST_W-1:0]     burst_len;
    logic [WSTART_W-1:0]    win_start;
    logic                   lit_phase;
    logic                   pin_level;
    logic [BURST_W-1:0]     burst_pos;
    logic [SUM_W-1:0]       win_sum;
    logic [SAMPLE_BITS-1:0] lit_avg;
    logic [SAMPLE_BITS-1:0] dark_avg;
    logic [1:0]             slots_filled;
    logic [ACC_W-1:0]       diff_acc;
    int                     diff_count;
    logic [SLOT_W-1:0]      ring_ptr;

    t_out_beat expected_readings[$];

    initial begin
        o_mismatch_count = 0;
        o_pending        = 0;
    end

    function automatic t_out_beat step_sampler(t_in_beat beat);
        t_out_beat              reading;
        logic [SAMPLE_BITS-1:0] level;
        reading = '0;
        if (beat.kind == KIND_TICK) begin
            pin_level = lit_phase;
            lit_phase = !lit_phase;
            burst_pos = '0;
            win_sum   = '0;
        end else if (burst_pos < burst_len) begin
            if (burst_pos >= win_start && int'(burst_pos) < int'(win_start) + WINDOW_LEN) begin
                win_sum = win_sum + SUM_W'(beat.sample);
            end
            burst_pos = burst_pos + BURST_W'(1);
            if (burst_pos == burst_len) begin
                level = SAMPLE_BITS'(win_sum >> WINDOW_LOG2);
                if (lit_phase) begin
                    lit_avg      = level;
                    slots_filled = slots_filled | SLOT_LIT;
                end else begin
                    dark_avg     = level;
                    slots_filled = slots_filled | SLOT_DARK;
                end
                if (slots_filled == SLOT_BOTH) begin
                    diff_acc   = diff_acc + ACC_W'(lit_avg) - ACC_W'(dark_avg);
                    diff_count = diff_count + 1;
                    if (diff_count >= DECIM_LEN) begin
                        diff_count         = 0;
                        reading.data_valid = 1'b1;
                        reading.data_value = DATA_W'(diff_acc >> DECIMATION_LOG2);
                        reading.slot_index = ring_ptr;
                        diff_acc           = '0;
                        ring_ptr           = ring_ptr + SLOT_W'(1);
                    end
                    slots_filled = '0;
                end
            end
        end
        reading.emitter_pin = pin_level;
        return reading;
    endfunction

    always @(posedge i_clk) begin : track_beats
        t_out_beat want;
        if (!i_rst_n) begin
            burst_len    = BURST_LENGTH_RESET;
            win_start    = WINDOW_START_RESET;
            lit_phase    = 1'b0;
            pin_level    = 1'b0;
            burst_pos    = BURST_LENGTH_RESET;
            win_sum      = '0;
            lit_avg      = '0;
            dark_avg     = '0;
            slots_filled = '0;
            diff_acc     = '0;
            diff_count   = 0;
            ring_ptr     = '0;
            expected_readings.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_BURST_LENGTH) begin
                    burst_len = i_cfg_data[BURST_W-1:0];
                end else if (i_cfg_index == CFG_WINDOW_START) begin
                    win_start = i_cfg_data[WSTART_W-1:0];
                end
            end
            if (i_result_ch.valid && i_result_ch.ready) begin
                if (expected_readings.size() == 0) begin
                    $error("Result beat arrived with no expectation waiting.");
                    o_mismatch_count++;
                end else begin
                    want = expected_readings.pop_front();
                    if (i_result_ch.data.emitter_pin !== want.emitter_pin) begin
                        $error("emitter_pin: expected %0d, actual %0d",
                               want.emitter_pin, i_result_ch.data.emitter_pin);
                        o_mismatch_count++;
                    end
                    if (i_result_ch.data.data_valid !== want.data_valid) begin
                        $error("data_valid: expected %0d, actual %0d",
                               want.data_valid, i_result_ch.data.data_valid);
                        o_mismatch_count++;
                    end
                    if (i_result_ch.data.data_value !== want.data_value) begin
                        $error("data_value: expected %0d, actual %0d",
                               want.data_value, i_result_ch.data.data_value);
                        o_mismatch_count++;
                    end
                    if (i_result_ch.data.slot_index !== want.slot_index) begin
                        $error("slot_index: expected %0d, actual %0d",
                               want.slot_index, i_result_ch.data.slot_index);
                        o_mismatch_count++;
                    end
                end
            end
            if (i_sample_ch.valid && i_sample_ch.ready) begin
                expected_readings.push_back(step_sampler(i_sample_ch.data));
            end
        end
        o_pending = expected_readings.size();
    end

endmodule

// File: bench/modulated_light_differential_sampler_top_tb.sv
`timescale 1ns / 100ps
// Top of the differential sampler testbench: clock, reset, stimulus, flow control and verdict.
module modulated_light_differential_sampler_top_tb;
    import mlds_pkg::*;

    localparam t_in_beat TICK_BEAT = {KIND_TICK, 12'h000};
    localparam t_in_beat FULL_BEAT = {KIND_SAMPLE, 12'hFFF};
    localparam t_in_beat ZERO_BEAT = {KIND_SAMPLE, 12'h000};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    int mismatch_count;
    int pending_count;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;
    int burst_len_cfg  = BURST_LENGTH_RESET;

    int idle_send[4]  = '{0, 56, 0, 33};
    int idle_recv[4]  = '{0, 0, 56, 33};
    int edge_len[6]   = '{8, 16, 8, 24, 16, 9};
    int edge_win[6]   = '{0, 8, 56, 0, 12, 1};

    t_in_beat directed_beats[25] = '{
        FULL_BEAT,
        TICK_BEAT, FULL_BEAT, FULL_BEAT,
        TICK_BEAT, ZERO_BEAT, ZERO_BEAT, ZERO_BEAT,
        TICK_BEAT, TICK_BEAT, ZERO_BEAT, ZERO_BEAT,
        TICK_BEAT, FULL_BEAT, FULL_BEAT,
        TICK_BEAT, ZERO_BEAT, ZERO_BEAT,
        TICK_BEAT, TICK_BEAT, ZERO_BEAT, ZERO_BEAT,
        TICK_BEAT, FULL_BEAT, FULL_BEAT
    };

    mlds_in_if  in_ch();
    mlds_out_if out_ch();

    modulated_light_differential_sampler_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    mlds_result_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_sample_ch      (in_ch),
        .i_result_ch      (out_ch),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [SAMPLE_BITS-1:0] pick_level();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return SAMPLE_BITS'($urandom_range(4095));
        endcase
    endfunction

    task automatic send_beat(input logic kind, input logic [SAMPLE_BITS-1:0] level);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.data.kind   <= kind;
        in_ch.data.sample <= level;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(input int bl_value, input int ws_value);
        wait_results_drained();
        write_reg(CFG_BURST_LENGTH, bl_value);
        write_reg(CFG_WINDOW_START, ws_value);
        burst_len_cfg = bl_value;
    endtask

    task automatic send_burst(input int count);
        send_beat(KIND_TICK, pick_level());
        for (int k = 0; k < count; k++) begin
            send_beat(KIND_SAMPLE, pick_level());
        end
    endtask

    task automatic run_random_bursts(input int target);
        int taken;
        int count;
        taken = 0;
        // Stray samples first: they may extend a burst left open under the previous setting.
        send_beat(KIND_SAMPLE, pick_level());
        send_beat(KIND_SAMPLE, pick_level());
        while (taken < target) begin
            if ($urandom_range(9) < 7) begin
                count = burst_len_cfg;
            end else begin
                count = $urandom_range(burst_len_cfg + 3);
            end
            send_burst(count);
            taken += 1 + ((count < burst_len_cfg) ? count : burst_len_cfg);
            if ($urandom_range(15) == 0) begin
                send_beat(KIND_SAMPLE, pick_level());
            end
        end
    endtask

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        out_ch.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The first beat lands on the burst that reset leaves closed.
        send_beat(directed_beats[0].kind, directed_beats[0].sample);
        configure(2, 0);
        for (int k = 1; k < 25; k++) begin
            send_beat(directed_beats[k].kind, directed_beats[k].sample);
        end

        // One-sample bursts emit a value every sixteen beats.
        configure(1, 0);
        for (int k = 0; k < 16; k++) begin
            send_burst(1);
        end

        for (int mode = 0; mode < 4; mode++) begin
            for (int sub = 0; sub < 3; sub++) begin
                if (mode * 3 + sub < 6) begin
                    configure(edge_len[mode * 3 + sub], edge_win[mode * 3 + sub]);
                end else begin
                    configure($urandom_range(14, 8), $urandom_range(24));
                end
                send_idle_pct  = idle_send[mode];
                recv_stall_pct = idle_recv[mode];
                if (mode == 0 && sub == 0) begin
                    hold_cycles = 300;
                end
                if (sub == 1) begin
                    run_random_bursts(6);
                    wait_results_drained();
                    run_random_bursts(6);
                end else begin
                    run_random_bursts(10);
                end
            end
        end

        configure(127, 63);
        send_burst(127);
        configure(0, 0);
        send_burst(4);

        wait_results_drained();
        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
